FILE: sv/homography_point_projection_assert.svh
// Assertion macros for the homography point projection block.
// Included by the top level; expects clk and rst in scope.
`ifndef HOMOGRAPHY_POINT_PROJECTION_ASSERT_SVH
`define HOMOGRAPHY_POINT_PROJECTION_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define HPP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define HPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/hpp_pkg.sv
// Shared constants, widths and the divider step for the homography projection.
// No dependencies.
package hpp_pkg;

  localparam int COORD_BITS = 16;
  // Coordinate bits actually used (fields are 16 bits wide)
  localparam int XB = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int PW = 33 + XB;
  localparam int SUM_W = (35 + XB > 46) ? 35 + XB : 46;
  localparam int QALIGN = 12;
  localparam int N_W = SUM_W + QALIGN;
  localparam int D_W = SUM_W;
  localparam int RW = D_W + 1;
  localparam int QW = 32;
  localparam int DIV_STAGES = QW / 2;
  // Divider latency: prep stage, step stages, rounding stage
  localparam int DIV_LAT = DIV_STAGES + 2;
  localparam int PIPE_LEN = DIV_LAT + 2;

  localparam int NUM_REGS = 8;
  localparam logic [2:0] REG_XX = 3'd0;
  localparam logic [2:0] REG_XY = 3'd1;
  localparam logic [2:0] REG_XT = 3'd2;
  localparam logic [2:0] REG_YX = 3'd3;
  localparam logic [2:0] REG_YY = 3'd4;
  localparam logic [2:0] REG_YT = 3'd5;
  localparam logic [2:0] REG_PP = 3'd6;
  localparam logic [2:0] REG_PC = 3'd7;

  localparam logic [31:0] ONE_Q16 = 32'd65536;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MIN = 32'h8000_0000;

  // One restoring division step: returns {quotient bit, new remainder}
  function automatic logic [RW:0] div_step(input logic [RW-1:0] rem,
                                           input logic [D_W-1:0] den,
                                           input logic nbit);
    logic [RW-1:0] t;
    logic [RW-1:0] d;
    t = {rem[RW-2:0], nbit};
    d = {1'b0, den};
    if (t >= d) begin
      return {1'b1, t - d};
    end
    return {1'b0, t};
  endfunction

endpackage

FILE: sv/hpp_div.sv
// Pipelined rounding divider for one projected coordinate.
// Depends on hpp_pkg; two quotient bits per stage.
module hpp_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [hpp_pkg::N_W-1:0]    num,
  input  logic [hpp_pkg::D_W-1:0]    den,
  input  logic                       neg,
  output logic [31:0]                q,
  output logic                       sat
);

  localparam int S = hpp_pkg::DIV_STAGES;

  logic [hpp_pkg::RW-1:0]  rem  [0:S];
  logic [hpp_pkg::QW-1:0]  quo  [0:S];
  logic [hpp_pkg::QW-1:0]  nlo  [0:S];
  logic [hpp_pkg::D_W-1:0] dreg [0:S];
  logic                    nreg [0:S];
  logic                    ovf  [0:S];

  logic [hpp_pkg::N_W+hpp_pkg::QW-1:0] num_ext;
  logic [hpp_pkg::N_W+hpp_pkg::QW-1:0] den_sh;
  assign num_ext = {{hpp_pkg::QW{1'b0}}, num};
  assign den_sh  = {{(hpp_pkg::N_W-hpp_pkg::D_W){1'b0}}, den, {hpp_pkg::QW{1'b0}}};

  // Prep: overflow check and initial partial remainder
  always_ff @(posedge clk) begin
    if (en) begin
      ovf[0]  <= (num_ext >= den_sh);
      rem[0]  <= hpp_pkg::RW'(num[hpp_pkg::N_W-1:hpp_pkg::QW]);
      quo[0]  <= '0;
      nlo[0]  <= num[hpp_pkg::QW-1:0];
      dreg[0] <= den;
      nreg[0] <= neg;
    end
  end

  // Step stages: two quotient bits each
  for (genvar s = 0; s < S; s++) begin : g_stage
    logic [hpp_pkg::RW:0] r1;
    logic [hpp_pkg::RW:0] r2;
    assign r1 = hpp_pkg::div_step(rem[s], dreg[s], nlo[s][hpp_pkg::QW-1]);
    assign r2 = hpp_pkg::div_step(r1[hpp_pkg::RW-1:0], dreg[s], nlo[s][hpp_pkg::QW-2]);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1]  <= r2[hpp_pkg::RW-1:0];
        quo[s+1]  <= {quo[s][hpp_pkg::QW-3:0], r1[hpp_pkg::RW], r2[hpp_pkg::RW]};
        nlo[s+1]  <= {nlo[s][hpp_pkg::QW-3:0], 2'b00};
        dreg[s+1] <= dreg[s];
        nreg[s+1] <= nreg[s];
        ovf[s+1]  <= ovf[s];
      end
    end
  end

  // Round half away from zero, apply sign, saturate
  logic        up;
  logic [32:0] q33;
  assign up  = ({rem[S], 1'b0} >= {2'b00, dreg[S]});
  assign q33 = {1'b0, quo[S]} + {32'd0, up};

  always_ff @(posedge clk) begin
    if (en) begin
      if (nreg[S]) begin
        if (ovf[S] || q33 > {1'b0, hpp_pkg::NEG_MIN}) begin
          sat <= 1'b1;
          q   <= hpp_pkg::NEG_MIN;
        end else begin
          sat <= 1'b0;
          q   <= 32'd0 - q33[31:0];
        end
      end else begin
        if (ovf[S] || q33 > {1'b0, hpp_pkg::POS_MAX}) begin
          sat <= 1'b1;
          q   <= hpp_pkg::POS_MAX;
        end else begin
          sat <= 1'b0;
          q   <= q33[31:0];
        end
      end
    end
  end

endmodule

FILE: sv/homography_point_projection.sv
// Top level of the homography point projection: config registers, multiply
// and sum stages, two hpp_div dividers. Depends on hpp_pkg, hpp_div, assert header.

// Maps pixel (src_x, src_y) through a 3x3 projective matrix and returns the
// rounded, saturated (dst_x, dst_y), with div_zero when the weight is zero.
// Accepts one item per clock while the pipeline advances; an accepted item
// passes the multiply stage, sum stage, divider prep, sixteen divider stages
// of two quotient bits each and the rounding stage. The whole pipeline
// advances when the output is empty or taken. Write configuration only while
// the pipeline is empty.
`include "homography_point_projection_assert.svh"

module homography_point_projection (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // src_x [15:0], src_y [31:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // dst_x [31:0], dst_y [63:32], div_zero [64],
                                 // saturated [65], zero pad [71:66]
);

  localparam int L = hpp_pkg::PIPE_LEN;

  logic [31:0] cxx, cxy, cxt, cyx, cyy, cyt, cpc;
  logic [63:0] cpp;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cxx <= hpp_pkg::ONE_Q16;
      cxy <= '0;
      cxt <= '0;
      cyx <= '0;
      cyy <= hpp_pkg::ONE_Q16;
      cyt <= '0;
      cpp <= '0;
      cpc <= hpp_pkg::ONE_Q16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hpp_pkg::REG_XX: cxx <= cfg_data[31:0];
        hpp_pkg::REG_XY: cxy <= cfg_data[31:0];
        hpp_pkg::REG_XT: cxt <= cfg_data[31:0];
        hpp_pkg::REG_YX: cyx <= cfg_data[31:0];
        hpp_pkg::REG_YY: cyy <= cfg_data[31:0];
        hpp_pkg::REG_YT: cyt <= cfg_data[31:0];
        hpp_pkg::REG_PP: cpp <= cfg_data;
        hpp_pkg::REG_PC: cpc <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Global advance
  logic en;
  assign en       = m_tready || !m_tvalid;
  assign s_tready = en;

  logic       vld  [0:L-1];
  logic       zero [2:L-1];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < L; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int i = 1; i < L; i++) vld[i] <= vld[i-1];
    end
  end

  // Stage 1: products
  logic signed [hpp_pkg::XB:0]   xs, ys;
  logic signed [hpp_pkg::PW-1:0] pxx, pxy, pyx, pyy, pwx, pwy;
  logic signed [31:0] txt, tyt, tpc;
  assign xs = $signed({1'b0, s_tdata[hpp_pkg::XB-1:0]});
  assign ys = $signed({1'b0, s_tdata[16+hpp_pkg::XB-1:16]});

  always_ff @(posedge clk) begin
    if (en) begin
      pxx <= $signed(cxx) * xs;
      pxy <= $signed(cxy) * ys;
      pyx <= $signed(cyx) * xs;
      pyy <= $signed(cyy) * ys;
      pwx <= $signed(cpp[31:0]) * xs;
      pwy <= $signed(cpp[63:32]) * ys;
      txt <= $signed(cxt);
      tyt <= $signed(cyt);
      tpc <= $signed(cpc);
    end
  end

  // Stage 2: sums
  logic signed [hpp_pkg::SUM_W-1:0] nx, ny, w;
  always_ff @(posedge clk) begin
    if (en) begin
      nx <= hpp_pkg::SUM_W'(pxx) + hpp_pkg::SUM_W'(pxy) + hpp_pkg::SUM_W'(txt);
      ny <= hpp_pkg::SUM_W'(pyx) + hpp_pkg::SUM_W'(pyy) + hpp_pkg::SUM_W'(tyt);
      w  <= hpp_pkg::SUM_W'(pwx) + hpp_pkg::SUM_W'(pwy)
          + (hpp_pkg::SUM_W'(tpc) <<< hpp_pkg::QALIGN);
    end
  end

  // Magnitudes and signs into the dividers
  logic [hpp_pkg::SUM_W-1:0] mx, my, mw;
  assign mx = nx[hpp_pkg::SUM_W-1] ? hpp_pkg::SUM_W'(-nx) : hpp_pkg::SUM_W'(nx);
  assign my = ny[hpp_pkg::SUM_W-1] ? hpp_pkg::SUM_W'(-ny) : hpp_pkg::SUM_W'(ny);
  assign mw = w[hpp_pkg::SUM_W-1]  ? hpp_pkg::SUM_W'(-w)  : hpp_pkg::SUM_W'(w);

  // Carry the zero-weight flag alongside the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      zero[2] <= (w == '0);
      for (int i = 3; i < L; i++) zero[i] <= zero[i-1];
    end
  end

  logic [31:0] qx, qy;
  logic        satx, saty;

  hpp_div u_div_x (
    .clk (clk), .en (en),
    .num ({mx, {hpp_pkg::QALIGN{1'b0}}}), .den (mw),
    .neg (nx[hpp_pkg::SUM_W-1] != w[hpp_pkg::SUM_W-1]),
    .q (qx), .sat (satx)
  );

  hpp_div u_div_y (
    .clk (clk), .en (en),
    .num ({my, {hpp_pkg::QALIGN{1'b0}}}), .den (mw),
    .neg (ny[hpp_pkg::SUM_W-1] != w[hpp_pkg::SUM_W-1]),
    .q (qy), .sat (saty)
  );

  // Output item
  logic        zo;
  logic        so;
  logic [31:0] dx, dy;
  assign zo = zero[L-1];
  assign dx = zo ? 32'd0 : qx;
  assign dy = zo ? 32'd0 : qy;
  assign so = !zo && (satx || saty);

  assign m_tvalid = vld[L-1];
  assign m_tdata  = {6'd0, so, zo, dy, dx};

  `HPP_ASSERT_IMPL(a_zero_clears, m_tvalid && m_tdata[64], m_tdata[63:0] == 64'd0 && !m_tdata[65], "zero weight item not cleared")
  `HPP_ASSERT_IMPL(a_sat_extreme, m_tvalid && m_tdata[65], (satx && (qx == hpp_pkg::POS_MAX || qx == hpp_pkg::NEG_MIN)) || (saty && (qy == hpp_pkg::POS_MAX || qy == hpp_pkg::NEG_MIN)), "saturated item not at range limit")
  `HPP_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled item changed")

endmodule

FILE: sim/testbench.sv
// Testbench for homography_point_projection: drives pixel coordinates through
// several matrix settings and checks each projected point against a local model.
// Depends on hpp_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic        saturated;
    logic        div_zero;
    logic [31:0] dst_y;
    logic [31:0] dst_x;
  } point_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;

  // Local copy of the matrix
  logic [31:0] m_xx, m_xy, m_xt, m_yx, m_yy, m_yt, m_pc;
  logic [63:0] m_pp;

  point_t projected_q[$];
  int     mismatches = 0;
  int     stall_cycles;
  bit     sink_hold;

  homography_point_projection dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("testbench: errors");
    $finish;
  end

  // Round |n| * 2^12 / |w| to nearest, ties away; saturate to signed 32 bits
  function automatic logic [31:0] divide_round(input logic signed [63:0] n,
                                               input logic signed [63:0] w,
                                               inout logic sat);
    logic          neg;
    logic [127:0]  mn, mw, q, r;
    neg = (n < 0) != (w < 0);
    mn = (n < 0) ? 128'(-n) : 128'(n);
    mw = (w < 0) ? 128'(-w) : 128'(w);
    mn = mn << 12;
    q = mn / mw;
    r = mn % mw;
    if (r >= mw - r) q = q + 1;
    if (neg) begin
      if (q > 128'h8000_0000) begin
        sat = 1'b1;
        return hpp_pkg::NEG_MIN;
      end
      return 32'(-q);
    end
    if (q > 128'h7FFF_FFFF) begin
      sat = 1'b1;
      return hpp_pkg::POS_MAX;
    end
    return q[31:0];
  endfunction

  function automatic point_t project_point(input logic [15:0] px, input logic [15:0] py);
    logic signed [63:0] x, y, nx, ny, w;
    point_t p;
    logic sat;
    x = {48'd0, px};
    y = {48'd0, py};
    nx = 64'(signed'(m_xx)) * x + 64'(signed'(m_xy)) * y + 64'(signed'(m_xt));
    ny = 64'(signed'(m_yx)) * x + 64'(signed'(m_yy)) * y + 64'(signed'(m_yt));
    w = 64'(signed'(m_pp[31:0])) * x + 64'(signed'(m_pp[63:32])) * y
        + 64'(signed'(m_pc)) * 64'sd4096;
    p = '0;
    sat = 1'b0;
    if (w == 0) begin
      p.div_zero = 1'b1;
      return p;
    end
    p.dst_x = divide_round(nx, w, sat);
    p.dst_y = divide_round(ny, w, sat);
    p.saturated = sat;
    return p;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Check each accepted item against the oldest projection
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      point_t got, want;
      got = m_tdata[65:0];
      if (projected_q.size() == 0) begin
        report("unexpected item", got.dst_x, 32'd0);
      end else begin
        want = projected_q.pop_front();
        if (got.dst_x !== want.dst_x) report("dst_x", got.dst_x, want.dst_x);
        if (got.dst_y !== want.dst_y) report("dst_y", got.dst_y, want.dst_y);
        if (got.div_zero !== want.div_zero)
          report("div_zero", 32'(got.div_zero), 32'(want.div_zero));
        if (got.saturated !== want.saturated)
          report("saturated", 32'(got.saturated), 32'(want.saturated));
        if (m_tdata[71:66] !== 6'd0) report("pad", 32'(m_tdata[71:66]), 32'd0);
      end
    end
  end

  // Random receiver stalls; a long hold when requested
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
      m_tready <= 1'b0;
    end else if (sink_hold) begin
      m_tready <= 1'b0;
    end else if (stall_cycles > 0) begin
      stall_cycles <= stall_cycles - 1;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 9) < 2) begin
      stall_cycles <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      hpp_pkg::REG_XX: m_xx = val[31:0];
      hpp_pkg::REG_XY: m_xy = val[31:0];
      hpp_pkg::REG_XT: m_xt = val[31:0];
      hpp_pkg::REG_YX: m_yx = val[31:0];
      hpp_pkg::REG_YY: m_yy = val[31:0];
      hpp_pkg::REG_YT: m_yt = val[31:0];
      hpp_pkg::REG_PP: m_pp = val;
      default: m_pc = val[31:0];
    endcase
  endtask

  task automatic load_matrix(input logic [31:0] xx, xy, xt, yx, yy, yt,
                             input logic [63:0] pp, input logic [31:0] pc);
    write_reg(hpp_pkg::REG_XX, {32'd0, xx});
    write_reg(hpp_pkg::REG_XY, {32'd0, xy});
    write_reg(hpp_pkg::REG_XT, {32'd0, xt});
    write_reg(hpp_pkg::REG_YX, {32'd0, yx});
    write_reg(hpp_pkg::REG_YY, {32'd0, yy});
    write_reg(hpp_pkg::REG_YT, {32'd0, yt});
    write_reg(hpp_pkg::REG_PP, pp);
    write_reg(hpp_pkg::REG_PC, {32'd0, pc});
  endtask

  // Send one item, optionally preceded by a random gap
  task automatic send_point(input logic [15:0] px, input logic [15:0] py, input bit gaps);
    int gap;
    if (gaps && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {py, px};
    projected_q.push_back(project_point(px, py));
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (projected_q.size() != 0) @(posedge clk);
    repeat (hpp_pkg::PIPE_LEN + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coef;
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(0, 262144)) - 131072);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_identity;
    send_point(16'd0, 16'd0, 0);
    send_point(16'hFFFF, 16'hFFFF, 0);
    send_point(16'hAAAA, 16'h5555, 0);
    send_point(16'h5555, 16'hAAAA, 0);
    send_point(16'd1, 16'hFFFF, 0);
    drain();
  endtask

  task automatic test_saturate_and_ties;
    // Extreme coefficients clip; half-pixel coefficients and offsets sum to whole pixels
    load_matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 64'd0, 32'd1);
    send_point(16'hFFFF, 16'hFFFF, 0);
    send_point(16'd0, 16'd0, 0);
    drain();
    load_matrix(32'h0000_8000, 32'hFFFF_8000, 32'h0000_8000, 32'hFFFF_8000,
                32'h0000_8000, 32'hFFFF_8000, 64'd0, 32'h0001_0000);
    send_point(16'd1, 16'd0, 0);
    send_point(16'd0, 16'd3, 0);
    send_point(16'd7, 16'd2, 0);
    drain();
  endtask

  task automatic test_zero_weight;
    // Zero weight at every point, and weight that cancels at one point
    load_matrix(32'h0001_0000, 32'd5, 32'd9, 32'd3, 32'h0001_0000, 32'd1, 64'd0, 32'd0);
    send_point(16'd10, 16'd20, 0);
    drain();
    load_matrix(32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'd0,
                {32'hF000_0000, 32'h1000_0000}, 32'd0);
    send_point(16'd4, 16'd4, 0);
    send_point(16'd4, 16'd5, 0);
    send_point(16'hFFFF, 16'd0, 0);
    drain();
    // Weight negative at the first point, positive at the second
    load_matrix(32'h0003_0000, 32'd0, 32'd0, 32'd0, 32'h0002_0000, 32'd0,
                {32'h8000_0000, 32'h7FFF_FFFF}, 32'h8000_0000);
    send_point(16'd100, 16'd200, 0);
    send_point(16'hFFFF, 16'h0000, 0);
    drain();
  endtask

  task automatic test_random;
    int k, j;
    for (k = 0; k < 8; k++) begin
      if (k == 7) begin
        load_matrix(32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'd0, 64'd0,
                    hpp_pkg::ONE_Q16);
      end else begin
        load_matrix(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                    rand_coef(), ($urandom_range(0, 2) == 0) ? 64'd0
                                 : {$urandom_range(0, 1) ? rand_coef() : ($urandom >> 8),
                                    $urandom_range(0, 1) ? rand_coef() : ($urandom >> 8)},
                    ($urandom_range(0, 5) == 0) ? 32'd0 : rand_coef());
      end
      for (j = 0; j < 95; j++)
        send_point($urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 15)) : 16'($urandom),
                   $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 15)) : 16'($urandom),
                   (j % 40) >= 10);
      drain();
    end
  endtask

  task automatic test_backpressure;
    int j;
    // Hold the receiver off while items keep coming until input stalls
    sink_hold = 1'b1;
    fork
      begin
        repeat (60) @(posedge clk);
        sink_hold = 1'b0;
      end
      for (j = 0; j < 50; j++) send_point(16'($urandom), 16'($urandom), 0);
    join
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = hpp_pkg::REG_XX;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    sink_hold = 1'b0;
    m_xx = hpp_pkg::ONE_Q16; m_xy = 0; m_xt = 0; m_yx = 0; m_yy = hpp_pkg::ONE_Q16;
    m_yt = 0; m_pp = 0; m_pc = hpp_pkg::ONE_Q16;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_identity();
    test_saturate_and_ties();
    test_zero_weight();
    test_backpressure();
    test_random();
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/hpp_pkg.sv
sv/hpp_div.sv
sv/homography_point_projection.sv
sim/testbench.sv
